### design/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte-forming functions of the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int JobqDepth = 4;
  localparam int JqAw      = $clog2(JobqDepth);
  localparam int CpW       = 21;

  localparam logic [5:0]     SurHiTag  = 6'b110110;
  localparam logic [5:0]     SurLoTag  = 6'b110111;
  localparam logic [CpW-1:0] SurBase   = 21'h10000;
  localparam logic [7:0]     Lead2     = 8'hc0;
  localparam logic [7:0]     Lead3     = 8'he0;
  localparam logic [7:0]     Lead4     = 8'hf0;
  localparam logic [7:0]     ContMark  = 8'h80;

  // One unit of work for the byte sequencer: an optional held high surrogate
  // to flush on its own, then an optional code point.
  typedef struct packed {
    logic           flush_valid;
    logic [9:0]     flush_bits;
    logic           cp_valid;
    logic [CpW-1:0] cp;
    logic           last;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [CpW-1:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < 21'h10000) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] cp,
                                           input logic [2:0]     len,
                                           input logic [1:0]     idx);
    logic [2:0] grp_sel;
    logic [5:0] grp;
    logic [7:0] b;
    grp_sel = len - 3'd1 - {1'b0, idx};
    case (grp_sel)
      3'd0:    grp = cp[5:0];
      3'd1:    grp = cp[11:6];
      default: grp = cp[17:12];
    endcase
    if (idx == 2'd0) begin
      case (len)
        3'd1:    b = {1'b0, cp[6:0]};
        3'd2:    b = Lead2 | {3'b000, cp[10:6]};
        3'd3:    b = Lead3 | {4'b0000, cp[15:12]};
        default: b = Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      b = ContMark | {2'b00, grp};
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### design/utf16_to_utf8_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_top
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing or CESU-8.
// ----------------------------------------------------------------------------
// A unit's job is first written into the job queue; its first byte is then
//   loaded into the output register.
// Throughput: one byte per cycle while pop is high and jobs wait, set by
//   the single output register; a unit gives 1 to 6 bytes (0 while held).
// Reset (rst, synchronous, active high) empties the job queue and output
//   register, clears any held surrogate and returns cesu_mode to 0.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_top import u16u8_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: cesu_mode is written when cfg_we is high.
  input  wire logic        cfg_we,
  input  wire logic        cesu_mode,
  // Input queue side.
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  // Output queue side.
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             string_end
);

  // The front end classifies each unit as it arrives and decides, with the
  // held high surrogate, what bytes it causes. It writes that decision as a
  // job into a short queue. A held high surrogate that is not yet resolved
  // causes no job.
  job_t job;
  job_t head;
  logic job_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic pending;

  // Input transfers are refused only when the job queue is full, so the
  // front keeps taking units while the back end is still emitting bytes.
  assign full = q_full;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cesu_mode),
    .push      (push),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job),
    .pending   (pending)
  );

  u16u8_jobq u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .rd_en   (q_pop),
    .head    (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // The back end walks through the bytes of the job at the queue head: the
  // flushed surrogate first, where there is one, then the code point. Each
  // byte lands in the output register, which is reloaded in the same cycle
  // as its transfer out, so bytes stream without a gap.
  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .string_end (string_end)
  );

  // The end of a string is always the last byte of its unit.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!string_end || last_byte))
    else $error("string_end without last_byte");

  // Nothing is held once the last unit of a string has been taken.
  a_no_pending_after_last: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_unit) |=> !pending)
    else $error("surrogate still held after last unit");

  // The back end never retires a job from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job retired from empty queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result waiting after reset");

endmodule
`default_nettype wire

### design/u16u8_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and queues work for the back end.
// ----------------------------------------------------------------------------
module u16u8_front import u16u8_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        push,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  input  wire logic        q_full,
  output logic             job_push,
  output job_t             job,
  output logic             pending
);

  logic       cesu_mode;
  logic       high_pending;
  logic       high_pending_next;
  logic [9:0] high_bits;
  logic [9:0] high_bits_next;
  logic       is_hi;
  logic       is_lo;
  logic       accept;

  assign is_hi  = (code_unit[15:10] == SurHiTag);
  assign is_lo  = (code_unit[15:10] == SurLoTag);
  assign accept = push && !q_full;

  always_comb begin
    job.flush_valid   = 1'b0;
    job.flush_bits    = high_bits;
    job.cp_valid      = 1'b0;
    job.cp            = {5'b00000, code_unit};
    job.last          = last_unit;
    high_pending_next = high_pending;
    high_bits_next    = high_bits;
    if (high_pending && is_lo && !cesu_mode) begin
      // Pair completes: one supplementary code point.
      job.cp_valid      = 1'b1;
      job.cp            = SurBase + {1'b0, high_bits, code_unit[9:0]};
      high_pending_next = 1'b0;
    end else begin
      if (high_pending) begin
        job.flush_valid   = 1'b1;
        high_pending_next = 1'b0;
      end
      if (is_hi && !cesu_mode && !last_unit) begin
        high_pending_next = 1'b1;
        high_bits_next    = code_unit[9:0];
      end else begin
        job.cp_valid = 1'b1;
      end
    end
  end

  assign job_push = accept && (job.flush_valid || job.cp_valid);
  assign pending  = high_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      cesu_mode    <= 1'b0;
      high_pending <= 1'b0;
      high_bits    <= '0;
    end else begin
      if (cfg_we) begin
        cesu_mode <= cfg_data;
      end
      if (accept) begin
        high_pending <= high_pending_next;
        high_bits    <= high_bits_next;
      end
    end
  end

endmodule
`default_nettype wire

### design/u16u8_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_jobq
// Short first-in first-out queue of jobs between front and back end.
// ----------------------------------------------------------------------------
module u16u8_jobq import u16u8_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      head,
  output logic      q_full,
  output logic      q_empty
);

  job_t            slots [JobqDepth];
  logic [JqAw-1:0] wr_ptr;
  logic [JqAw-1:0] rd_ptr;
  logic [JqAw:0]   count;

  assign q_full  = (count == (JqAw + 1)'(JobqDepth));
  assign q_empty = (count == '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule
`default_nettype wire

### design/u16u8_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// Byte sequencer: turns each queued job into UTF-8 bytes, one per cycle while the output is taken.
// ----------------------------------------------------------------------------
module u16u8_back import u16u8_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t head,
  input  wire logic q_empty,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output logic [7:0] out_byte,
  output logic      last_byte,
  output logic      string_end
);

  logic           out_valid;
  logic           seg;
  logic [1:0]     idx;
  logic           advance;
  logic           go;
  logic           in_cp_seg;
  logic [CpW-1:0] point;
  logic [2:0]     len;
  logic [7:0]     cur_byte;
  logic           seg_end;
  logic           job_end;

  assign advance   = !out_valid || pop;
  assign go        = advance && !q_empty;
  assign in_cp_seg = seg || !head.flush_valid;
  assign point     = in_cp_seg ? head.cp : {5'b00000, SurHiTag, head.flush_bits};
  assign len       = utf8_len(point);
  assign cur_byte  = utf8_byte(point, len, idx);
  assign seg_end   = ({1'b0, idx} == (len - 3'd1));
  assign job_end   = seg_end && (in_cp_seg || !head.cp_valid);
  assign q_pop     = go && job_end;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seg       <= 1'b0;
      idx       <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
        if (job_end) begin
          seg <= 1'b0;
          idx <= '0;
        end else if (seg_end) begin
          seg <= 1'b1;
          idx <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte   <= cur_byte;
      last_byte  <= job_end;
      string_end <= job_end && head.last;
    end
  end

endmodule
`default_nettype wire

### test/utf16_to_utf8_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_top_test
// Self-checking bench for the UTF-16 to UTF-8 encoder. A table of directed
// code units covers the range edges, surrogate pairing, flushing of held
// surrogates and CESU-8 mode. Random strings follow, mostly well-formed with
// some stray surrogates and raw noise, across several mode settings. Every
// output byte is checked against a typed row or a byte-level bench encoder.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_top_test;

  // Upper six bits that mark high and low surrogates.
  localparam logic [5:0]  HiTag        = 6'b110110;
  localparam logic [5:0]  LoTag        = 6'b110111;
  localparam logic [20:0] SupplBase    = 21'h10000;
  // Idle cycles allowed after the last expected byte before we touch the
  // mode register or declare the run over.
  localparam int          SettleCycles = 8;
  localparam int          CycleLimit   = 400000;
  localparam int          RandomPhases = 6;
  localparam int          PhaseUnits   = 60;

  // Kinds of code unit drawn by the random string generator.
  typedef enum int {
    UcAscii, UcTwo, UcThree, UcPair, UcLoneHi, UcLoneLo, UcAny, UcEdge
  } unit_class_e;

  // One expected output byte with its two end markers.
  typedef struct packed {
    logic [7:0] data;
    logic       fin_item;
    logic       fin_string;
  } utf8_byte_t;

  // One directed stimulus row. Where typed is set, bytes holds the expected
  // output right-aligned, first byte most significant.
  typedef struct packed {
    logic        mode;
    logic [15:0] code;
    logic        fin;
    logic        typed;
    logic [2:0]  nbytes;
    logic [31:0] bytes;
  } dir_row_t;

  localparam logic [15:0] EdgeUnits [12] = '{
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
    16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFF
  };

  // Rows without a typed result are checked against the bench encoder only.
  dir_row_t dir_table [25] = '{
    '{1'b0, 16'h0000, 1'b1, 1'b1, 3'd1, 32'h00},
    '{1'b0, 16'h007F, 1'b0, 1'b1, 3'd1, 32'h7F},
    '{1'b0, 16'h0080, 1'b0, 1'b1, 3'd2, 32'hC280},
    '{1'b0, 16'h07FF, 1'b0, 1'b1, 3'd2, 32'hDFBF},
    '{1'b0, 16'h0800, 1'b0, 1'b1, 3'd3, 32'hE0A080},
    '{1'b0, 16'hFFFF, 1'b1, 1'b1, 3'd3, 32'hEFBFBF},
    '{1'b0, 16'hD800, 1'b0, 1'b1, 3'd0, 32'h0},
    '{1'b0, 16'hDC00, 1'b1, 1'b1, 3'd4, 32'hF0908080},
    '{1'b0, 16'hDBFF, 1'b0, 1'b1, 3'd0, 32'h0},
    '{1'b0, 16'hDFFF, 1'b0, 1'b1, 3'd4, 32'hF48FBFBF},
    '{1'b0, 16'hD83D, 1'b0, 1'b1, 3'd0, 32'h0},
    '{1'b0, 16'h0041, 1'b0, 1'b1, 3'd4, 32'hEDA0BD41},
    '{1'b0, 16'hDBFF, 1'b1, 1'b1, 3'd3, 32'hEDAFBF},
    '{1'b0, 16'hDC00, 1'b0, 1'b1, 3'd3, 32'hEDB080},
    '{1'b0, 16'hD800, 1'b0, 1'b1, 3'd0, 32'h0},
    '{1'b0, 16'hDBFF, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 16'h20AC, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b0, 16'hD801, 1'b0, 1'b1, 3'd0, 32'h0},
    '{1'b1, 16'hDC37, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b1, 16'hD800, 1'b0, 1'b1, 3'd3, 32'hEDA080},
    '{1'b1, 16'hDBFF, 1'b0, 1'b1, 3'd3, 32'hEDAFBF},
    '{1'b1, 16'hDC00, 1'b1, 1'b1, 3'd3, 32'hEDB080},
    '{1'b1, 16'h00E9, 1'b1, 1'b0, 3'd0, 32'h0},
    '{1'b0, 16'hA5A5, 1'b0, 1'b0, 3'd0, 32'h0},
    '{1'b0, 16'h5A5A, 1'b1, 1'b0, 3'd0, 32'h0}
  };

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic        cfg_mode   = 1'b0;
  logic        push       = 1'b0;
  logic [15:0] code_unit  = 16'h0000;
  logic        last_unit  = 1'b0;
  logic        pop        = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        string_end;

  // Bench copy of the encoder state and of the mode register.
  logic        cesu_now   = 1'b0;
  logic        held_high  = 1'b0;
  logic [9:0]  held_bits  = 10'd0;

  logic [7:0]  step_bytes [$];
  utf8_byte_t  expected_bytes [$];
  utf8_byte_t  oldest;

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          units_sent     = 0;
  int          burst_left     = 0;
  int          pop_window     = 0;
  logic [15:0] pop_pattern    = 16'hFFFF;
  logic [3:0]  pop_phase      = 4'd0;

  utf16_to_utf8_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cesu_mode  (cfg_mode),
    .push       (push),
    .full       (full),
    .code_unit  (code_unit),
    .last_unit  (last_unit),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .string_end (string_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A hung handshake or a byte that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               expected_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Appends the UTF-8 form of one code point to step_bytes.
  function automatic void utf8_of_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      step_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      step_bytes.push_back({3'b110, cp[10:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      step_bytes.push_back({4'b1110, cp[15:12]});
      step_bytes.push_back({2'b10, cp[11:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      step_bytes.push_back({5'b11110, cp[20:18]});
      step_bytes.push_back({2'b10, cp[17:12]});
      step_bytes.push_back({2'b10, cp[11:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Works out the bytes caused by one accepted code unit and advances the
  // bench copy of the surrogate state.
  function automatic void encode_unit(input logic [15:0] cu, input logic fin);
    logic is_hi;
    logic is_lo;
    logic paired;
    is_hi  = (cu[15:10] == HiTag);
    is_lo  = (cu[15:10] == LoTag);
    paired = 1'b0;
    step_bytes.delete();
    if (held_high) begin
      // A held high surrogate either pairs with this low one or goes out
      // on its own ahead of whatever this unit produces.
      if (is_lo && !cesu_now) begin
        utf8_of_point(SupplBase + {1'b0, held_bits, cu[9:0]});
        paired = 1'b1;
      end else begin
        utf8_of_point({5'd0, HiTag, held_bits});
      end
      held_high = 1'b0;
      held_bits = 10'd0;
    end
    if (!paired) begin
      if (is_hi && !cesu_now && !fin) begin
        held_high = 1'b1;
        held_bits = cu[9:0];
      end else begin
        utf8_of_point({5'd0, cu});
      end
    end
  endfunction

  // Offers one code unit, waits for its transfer, records what it should
  // produce, and then keeps to the sender's burst and gap rhythm.
  task automatic send_unit(input logic [15:0] cu, input logic fin, input logic typed,
                           input logic [2:0] nbytes, input logic [31:0] bytes);
    int n;
    int gap;
    @(negedge clk);
    push      <= 1'b1;
    code_unit <= cu;
    last_unit <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    units_sent++;
    encode_unit(cu, fin);
    if (typed) begin
      // The typed row overrides the bench encoder as the expectation.
      n = int'(nbytes);
      step_bytes.delete();
      for (int i = 0; i < n; i++) step_bytes.push_back(bytes[8*(n-1-i) +: 8]);
    end
    n = step_bytes.size();
    for (int i = 0; i < n; i++)
      expected_bytes.push_back('{step_bytes[i], i == n - 1, fin && (i == n - 1)});
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Stops offering units and waits until every expected byte has come out,
  // plus a short settling time in case the block is still busy.
  task automatic wait_drain();
    @(negedge clk);
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_mode <= m;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cesu_now = m;
  endtask

  // Builds one random string, mostly valid text with surrogate pairs, and
  // now and then a stray surrogate or a raw 16-bit value.
  task automatic send_string();
    logic [15:0] units [$];
    unit_class_e cls;
    int          len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      if ($urandom_range(0, 2) == 0) begin
        cls = UcPair;
      end else begin
        cls = unit_class_e'($urandom_range(0, 7));
      end
      case (cls)
        UcAscii:  units.push_back(16'($urandom_range(0, 16'h7F)));
        UcTwo:    units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
        UcThree: begin
          if ($urandom_range(0, 1) == 0) begin
            units.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
          end else begin
            units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
          end
        end
        UcPair: begin
          units.push_back({HiTag, 10'($urandom)});
          units.push_back({LoTag, 10'($urandom)});
        end
        UcLoneHi: units.push_back({HiTag, 10'($urandom)});
        UcLoneLo: units.push_back({LoTag, 10'($urandom)});
        UcAny:    units.push_back(16'($urandom));
        default:  units.push_back(EdgeUnits[$urandom_range(0, 11)]);
      endcase
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1, 1'b0, 3'd0, 32'h0);
  endtask

  // The receiver takes bytes on a rotating 16-bit pattern that is redrawn
  // whenever its window runs out: sometimes no stalls, sometimes dense or sparse.
  always @(negedge clk) begin
    if (pop_window == 0) begin
      pop_window = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       pop_pattern = 16'hFFFF;
        1:       pop_pattern = 16'($urandom) | 16'h0001;
        2:       pop_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: pop_pattern = 16'($urandom | $urandom);
      endcase
    end
    pop_window--;
    pop       <= pop_pattern[pop_phase];
    pop_phase <= pop_phase + 4'd1;
  end

  // Every byte transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte));
      end else begin
        oldest = expected_bytes.pop_front();
        if (out_byte !== oldest.data)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, oldest.data));
        if (last_byte !== oldest.fin_item)
          report_mismatch($sformatf("last_byte %b, wanted %b on byte %02h",
                                    last_byte, oldest.fin_item, oldest.data));
        if (string_end !== oldest.fin_string)
          report_mismatch($sformatf("string_end %b, wanted %b on byte %02h",
                                    string_end, oldest.fin_string, oldest.data));
      end
    end
  end

  initial begin
    int phase_goal;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 24);

    // Directed table. The mode register is written once after reset and
    // again wherever a row asks for the other mode, including once while a
    // high surrogate is held.
    write_mode(1'b0);
    foreach (dir_table[r]) begin
      if (dir_table[r].mode != cesu_now) write_mode(dir_table[r].mode);
      send_unit(dir_table[r].code, dir_table[r].fin, dir_table[r].typed,
                dir_table[r].nbytes, dir_table[r].bytes);
    end

    // Random strings, with the mode alternating from one phase to the next.
    phase_goal = units_sent;
    for (int p = 0; p < RandomPhases; p++) begin
      write_mode(p % 2 == 1);
      phase_goal += PhaseUnits;
      while (units_sent < phase_goal) send_string();
    end

    // Any byte still owed at this point leaves the run to the timeout.
    wait_drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
